// ===== sv/cpu_6502_instruction_step_macros.svh =====
// ----------------------------------------------------------------------------
// cpu_6502_instruction_step assertion macros
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CPU_6502_INSTRUCTION_STEP_MACROS_SVH
`define CPU_6502_INSTRUCTION_STEP_MACROS_SVH

// same-cycle implication
`define C65_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define C65_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/c65_pkg.sv =====
// ----------------------------------------------------------------------------
// c65_pkg
// Types, constants, opcode decode and ALU helpers of the 6502 step core.
// ----------------------------------------------------------------------------
package c65_pkg;

    localparam int unsigned MEM_ADDR_BITS_DEF = 16;
    localparam int unsigned IN_TDATA_W        = 24;
    localparam int unsigned OUT_TDATA_W       = 80;

    localparam logic [15:0] START_ADDR_RST = 16'hC000;
    localparam logic [7:0]  SP_RST         = 8'hFD;
    localparam logic [7:0]  P_RST          = 8'h24;
    localparam logic [7:0]  STACK_PAGE     = 8'h01;
    localparam logic [7:0]  ZERO_PAGE      = 8'h00;
    localparam logic [15:0] BRK_VEC_LO     = 16'hFFFE;
    localparam logic [15:0] BRK_VEC_HI     = 16'hFFFF;
    localparam logic [7:0]  PUSH_P_SET     = 8'h30;
    localparam logic [7:0]  PULL_P_MASK    = 8'hCF;
    localparam logic [7:0]  PULL_P_SET     = 8'h20;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_EXEC = 2'd2;

    localparam int FB_C = 0;
    localparam int FB_Z = 1;
    localparam int FB_I = 2;
    localparam int FB_D = 3;
    localparam int FB_V = 6;
    localparam int FB_N = 7;

    localparam logic [1:0] GRP_0 = 2'b00;
    localparam logic [1:0] GRP_1 = 2'b01;
    localparam logic [1:0] GRP_2 = 2'b10;

    localparam logic [2:0] AAA_ORA = 3'd0;
    localparam logic [2:0] AAA_AND = 3'd1;
    localparam logic [2:0] AAA_EOR = 3'd2;
    localparam logic [2:0] AAA_ADC = 3'd3;
    localparam logic [2:0] AAA_STO = 3'd4;
    localparam logic [2:0] AAA_LOD = 3'd5;
    localparam logic [2:0] AAA_CMP = 3'd6;
    localparam logic [2:0] AAA_SBC = 3'd7;

    localparam logic [7:0] OP_BRK   = 8'h00;
    localparam logic [7:0] OP_JSR   = 8'h20;
    localparam logic [7:0] OP_RTI   = 8'h40;
    localparam logic [7:0] OP_RTS   = 8'h60;
    localparam logic [7:0] OP_JMP   = 8'h4C;
    localparam logic [7:0] OP_JMPI  = 8'h6C;
    localparam logic [7:0] OP_PHP   = 8'h08;
    localparam logic [7:0] OP_PLP   = 8'h28;
    localparam logic [7:0] OP_PHA   = 8'h48;
    localparam logic [7:0] OP_PLA   = 8'h68;
    localparam logic [7:0] OP_DEY   = 8'h88;
    localparam logic [7:0] OP_INY   = 8'hC8;
    localparam logic [7:0] OP_DEX   = 8'hCA;
    localparam logic [7:0] OP_INX   = 8'hE8;
    localparam logic [7:0] OP_TXA   = 8'h8A;
    localparam logic [7:0] OP_TAX   = 8'hAA;
    localparam logic [7:0] OP_TYA   = 8'h98;
    localparam logic [7:0] OP_TAY   = 8'hA8;
    localparam logic [7:0] OP_TXS   = 8'h9A;
    localparam logic [7:0] OP_TSX   = 8'hBA;
    localparam logic [7:0] OP_NOP   = 8'hEA;
    localparam logic [7:0] OP_CLC   = 8'h18;
    localparam logic [7:0] OP_SEC   = 8'h38;
    localparam logic [7:0] OP_CLI   = 8'h58;
    localparam logic [7:0] OP_SEI   = 8'h78;
    localparam logic [7:0] OP_CLV   = 8'hB8;
    localparam logic [7:0] OP_CLD   = 8'hD8;
    localparam logic [7:0] OP_SED   = 8'hF8;
    localparam logic [7:0] OP_ASL_A = 8'h0A;
    localparam logic [7:0] OP_ROL_A = 8'h2A;
    localparam logic [7:0] OP_LSR_A = 8'h4A;
    localparam logic [7:0] OP_ROR_A = 8'h6A;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RDWAIT, ST_OP, ST_B1, ST_B2, ST_VLO, ST_VHI,
        ST_ADDR, ST_DATA, ST_PUSH, ST_PULL, ST_FIN
    } t_state;

    typedef enum logic [3:0] {
        M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY, M_IZX, M_IZY, M_ACC, M_NONE
    } t_mode;

    typedef enum logic [3:0] {
        CL_UNK, CL_BRANCH, CL_BRK, CL_JSR, CL_RTI, CL_RTS, CL_JMP, CL_JMPI,
        CL_PHP, CL_PLP, CL_PHA, CL_PLA, CL_IMPL, CL_MEM
    } t_class;

    typedef struct packed {
        logic        en;
        logic        we;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } t_mem_req;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] pc_out;
        logic [7:0]  acc_out;
        logic [7:0]  xreg_out;
        logic [7:0]  yreg_out;
        logic [7:0]  sp_out;
        logic [7:0]  status_out;
        logic [2:0]  cycles_taken;
        logic [7:0]  opcode_out;
        logic        unknown_op;
    } t_result;

    // base cycles, one nibble per opcode, 0 = unofficial
    localparam logic [127:0] CYC_ROW [8] = '{
        128'h76000350322004602500046024000470,
        128'h66003350422044602500046024000470,
        128'h66000350322034602500046024000470,
        128'h66000350422054602500046024000470,
        128'h06003330202044402600444025200500,
        128'h26203330222044402500444024204440,
        128'h26003350222044602500046024000470,
        128'h26003350222044602500046024000470
    };

    function automatic logic [2:0] f_base_cyc(input logic [7:0] op);
        logic [3:0] nib;
        nib = CYC_ROW[op[7:5]][{~op[4:0], 2'b00} +: 4];
        return nib[2:0];
    endfunction

    function automatic t_mode f_mode(input logic [7:0] op);
        t_mode m;
        if (op[1:0] == GRP_1) begin
            unique case (op[4:2])
                3'd0:    m = M_IZX;
                3'd1:    m = M_ZP;
                3'd2:    m = M_IMM;
                3'd3:    m = M_ABS;
                3'd4:    m = M_IZY;
                3'd5:    m = M_ZPX;
                3'd6:    m = M_ABY;
                default: m = M_ABX;
            endcase
        end else begin
            unique case (op[4:2])
                3'd0:    m = M_IMM;
                3'd1:    m = M_ZP;
                3'd2:    m = M_ACC;
                3'd3:    m = M_ABS;
                3'd5:    m = M_ZPX;
                3'd7:    m = M_ABX;
                default: m = M_NONE;
            endcase
            if (op[1:0] == GRP_2 && (op[7:5] == AAA_STO || op[7:5] == AAA_LOD)) begin
                if (m == M_ZPX) m = M_ZPY;
                if (m == M_ABX) m = M_ABY;
            end
        end
        return m;
    endfunction

    function automatic t_class f_class(input logic [7:0] op);
        t_class c;
        if (f_base_cyc(op) == 3'd0) begin
            c = CL_UNK;
        end else if (op[4:0] == 5'h10) begin
            c = CL_BRANCH;
        end else begin
            unique case (op) inside
                OP_BRK:  c = CL_BRK;
                OP_JSR:  c = CL_JSR;
                OP_RTI:  c = CL_RTI;
                OP_RTS:  c = CL_RTS;
                OP_JMP:  c = CL_JMP;
                OP_JMPI: c = CL_JMPI;
                OP_PHP:  c = CL_PHP;
                OP_PLP:  c = CL_PLP;
                OP_PHA:  c = CL_PHA;
                OP_PLA:  c = CL_PLA;
                OP_DEY, OP_INY, OP_DEX, OP_INX, OP_TXA, OP_TAX, OP_TYA, OP_TAY,
                OP_TXS, OP_TSX, OP_NOP, OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_CLV,
                OP_CLD, OP_SED, OP_ASL_A, OP_ROL_A, OP_LSR_A, OP_ROR_A:
                    c = CL_IMPL;
                default: c = (f_mode(op) == M_NONE) ? CL_UNK : CL_MEM;
            endcase
        end
        return c;
    endfunction

    function automatic logic [7:0] f_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q       = p;
        q[FB_Z] = (v == 8'd0);
        q[FB_N] = v[7];
        return q;
    endfunction

    // {flags, acc}
    function automatic logic [15:0] f_adc(input logic [7:0] a, input logic [7:0] m,
                                          input logic [7:0] p);
        logic [8:0] s;
        logic [7:0] q;
        s       = {1'b0, a} + {1'b0, m} + {8'd0, p[FB_C]};
        q       = f_nz(p, s[7:0]);
        q[FB_C] = s[8];
        q[FB_V] = ~(a[7] ^ m[7]) & (a[7] ^ s[7]);
        return {q, s[7:0]};
    endfunction

    function automatic logic [7:0] f_cmp(input logic [7:0] r, input logic [7:0] m,
                                         input logic [7:0] p);
        logic [8:0] d;
        logic [7:0] q;
        d       = {1'b0, r} - {1'b0, m};
        q       = f_nz(p, d[7:0]);
        q[FB_C] = ~d[8];
        return q;
    endfunction

    // kind: 0 ASL, 1 ROL, 2 LSR, 3 ROR; {flags, value}
    function automatic logic [15:0] f_shift(input logic [1:0] kind, input logic [7:0] v,
                                            input logic [7:0] p);
        logic [7:0] r;
        logic [7:0] q;
        q = p;
        case (kind)
            2'd0:    begin r = {v[6:0], 1'b0};    q[FB_C] = v[7]; end
            2'd1:    begin r = {v[6:0], p[FB_C]}; q[FB_C] = v[7]; end
            2'd2:    begin r = {1'b0, v[7:1]};    q[FB_C] = v[0]; end
            default: begin r = {p[FB_C], v[7:1]}; q[FB_C] = v[0]; end
        endcase
        q = f_nz(q, r);
        return {q, r};
    endfunction

endpackage

// ===== sv/c65_mem.sv =====
// ----------------------------------------------------------------------------
// c65_mem
// Single-port byte memory, registered read, one access per cycle.
// ----------------------------------------------------------------------------
module c65_mem #(
    parameter int unsigned ADDR_BITS = c65_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic              i_clk,
    input  c65_pkg::t_mem_req i_req,
    output logic [7:0]        o_rdata
);
    import c65_pkg::*;

    localparam int unsigned DEPTH = 1 << ADDR_BITS;

    logic [7:0]           r_mem [DEPTH];
    logic [7:0]           r_rdata;
    logic [ADDR_BITS-1:0] idx;

    assign idx     = i_req.addr[ADDR_BITS-1:0];
    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            if (i_req.we) begin
                r_mem[idx] <= i_req.wdata;
            end else begin
                r_rdata <= r_mem[idx];
            end
        end
    end

endmodule

// ===== sv/c65_core.sv =====
// ----------------------------------------------------------------------------
// c65_core
// Command sequencer and register file: walks one instruction through its
// memory accesses, at most one access per state, and holds the result.
// ----------------------------------------------------------------------------
module c65_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_cmd,
    input  logic [15:0]       i_addr,
    input  logic [7:0]        i_data,
    input  logic              i_cfg_valid,
    input  logic [15:0]       i_cfg_data,
    output c65_pkg::t_mem_req o_mem_req,
    input  logic [7:0]        i_rdata,
    output logic              o_fin,
    input  logic              i_ack,
    output c65_pkg::t_result  o_res
);
    import c65_pkg::*;

    t_state      r_state, n_state;
    t_class      r_cls, n_cls;
    t_mode       r_mode, n_mode;
    logic [15:0] r_pc, n_pc;
    logic [7:0]  r_a, n_a, r_x, n_x, r_y, n_y, r_sp, n_sp, r_p, n_p;
    logic [7:0]  r_op, n_op, r_b1, n_b1, r_lo, n_lo, r_rdata, n_rdata;
    logic [15:0] r_ea, n_ea, r_ea2, n_ea2;
    logic [2:0]  r_cyc, n_cyc;
    logic        r_unk, n_unk, r_cross, n_cross;
    logic [1:0]  r_step, n_step;
    t_mem_req    mreq;

    t_class      cls_in;
    t_mode       mode_in;
    logic [2:0]  aaa;
    logic [1:0]  grp;
    logic        accept;
    logic        pull_more;

    assign cls_in     = f_class(i_rdata);
    assign mode_in    = f_mode(i_rdata);
    assign aaa        = r_op[7:5];
    assign grp        = r_op[1:0];
    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_fin      = (r_state == ST_FIN);
    assign o_mem_req  = mreq;
    assign pull_more  = (r_cls == CL_RTI && r_step != 2'd2) ||
                        (r_cls == CL_RTS && r_step == 2'd0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_READ)      n_state = ST_RDWAIT;
                    else if (i_cmd == CMD_EXEC) n_state = ST_OP;
                    else                        n_state = ST_FIN;
                end
            end
            ST_RDWAIT: n_state = ST_FIN;
            ST_OP: begin
                unique case (cls_in)
                    CL_UNK, CL_IMPL, CL_PHP, CL_PHA: n_state = ST_FIN;
                    CL_PLP, CL_PLA, CL_RTI, CL_RTS:   n_state = ST_PULL;
                    CL_BRK:                           n_state = ST_PUSH;
                    default:                          n_state = ST_B1;
                endcase
            end
            ST_B1: begin
                if (r_cls == CL_BRANCH) n_state = ST_FIN;
                else if (r_cls == CL_MEM && (r_mode == M_IZX || r_mode == M_IZY))
                    n_state = ST_VLO;
                else if (r_cls == CL_MEM && r_mode != M_ABS && r_mode != M_ABX &&
                         r_mode != M_ABY)
                    n_state = ST_ADDR;
                else n_state = ST_B2;
            end
            ST_B2: begin
                if (r_cls == CL_JMP)       n_state = ST_FIN;
                else if (r_cls == CL_JSR)  n_state = ST_PUSH;
                else if (r_cls == CL_JMPI) n_state = ST_VLO;
                else                       n_state = ST_ADDR;
            end
            ST_VLO: n_state = ST_VHI;
            ST_VHI: n_state = (r_cls == CL_MEM) ? ST_ADDR : ST_FIN;
            ST_ADDR: n_state = (aaa == AAA_STO) ? ST_FIN : ST_DATA;
            ST_DATA: n_state = ST_FIN;
            ST_PUSH: begin
                if (r_cls == CL_BRK && r_step == 2'd3)      n_state = ST_VLO;
                else if (r_cls == CL_JSR && r_step == 2'd1) n_state = ST_FIN;
            end
            ST_PULL: n_state = pull_more ? ST_PULL : ST_FIN;
            ST_FIN:  n_state = i_ack ? ST_IDLE : ST_FIN;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        logic [15:0] w, s16, ret, nxt, tgt;
        logic [15:0] fr;
        logic [7:0]  t8, m;
        logic        take;
        w     = {i_rdata, r_b1};
        s16   = 16'd0;
        ret   = r_pc + 16'd2;
        nxt   = r_pc + 16'd2;
        tgt   = nxt + {{8{i_rdata[7]}}, i_rdata};
        fr    = 16'd0;
        t8    = 8'd0;
        m     = i_rdata;
        take  = 1'b0;
        n_cls = r_cls;   n_mode = r_mode; n_pc = r_pc;   n_a = r_a;   n_x = r_x;
        n_y = r_y;       n_sp = r_sp;     n_p = r_p;     n_op = r_op; n_b1 = r_b1;
        n_lo = r_lo;     n_rdata = r_rdata; n_ea = r_ea; n_ea2 = r_ea2;
        n_cyc = r_cyc;   n_unk = r_unk;   n_cross = r_cross; n_step = r_step;
        mreq  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cfg_valid) n_pc = i_cfg_data;
                if (accept) begin
                    n_rdata = 8'd0; n_cyc = 3'd0; n_op = 8'd0; n_unk = 1'b0;
                    case (i_cmd)
                        CMD_LOAD: mreq = '{en: 1'b1, we: 1'b1, addr: i_addr, wdata: i_data};
                        CMD_READ: mreq = '{en: 1'b1, we: 1'b0, addr: i_addr, wdata: 8'd0};
                        CMD_EXEC: mreq = '{en: 1'b1, we: 1'b0, addr: r_pc, wdata: 8'd0};
                        default:  mreq = '0;
                    endcase
                end
            end
            ST_RDWAIT: n_rdata = i_rdata;
            ST_OP: begin
                n_op = i_rdata; n_cls = cls_in; n_mode = mode_in;
                n_cyc = f_base_cyc(i_rdata); n_cross = 1'b0; n_step = 2'd0;
                unique case (cls_in)
                    CL_UNK: begin
                        n_unk = 1'b1; n_cyc = 3'd2; n_pc = r_pc + 16'd1;
                    end
                    CL_IMPL: begin
                        n_pc = r_pc + 16'd1;
                        case (i_rdata)
                            OP_DEY: begin n_y = r_y - 8'd1; n_p = f_nz(r_p, n_y); end
                            OP_INY: begin n_y = r_y + 8'd1; n_p = f_nz(r_p, n_y); end
                            OP_DEX: begin n_x = r_x - 8'd1; n_p = f_nz(r_p, n_x); end
                            OP_INX: begin n_x = r_x + 8'd1; n_p = f_nz(r_p, n_x); end
                            OP_TXA: begin n_a = r_x; n_p = f_nz(r_p, r_x); end
                            OP_TAX: begin n_x = r_a; n_p = f_nz(r_p, r_a); end
                            OP_TYA: begin n_a = r_y; n_p = f_nz(r_p, r_y); end
                            OP_TAY: begin n_y = r_a; n_p = f_nz(r_p, r_a); end
                            OP_TXS: n_sp = r_x;
                            OP_TSX: begin n_x = r_sp; n_p = f_nz(r_p, r_sp); end
                            OP_CLC: n_p[FB_C] = 1'b0;
                            OP_SEC: n_p[FB_C] = 1'b1;
                            OP_CLI: n_p[FB_I] = 1'b0;
                            OP_SEI: n_p[FB_I] = 1'b1;
                            OP_CLV: n_p[FB_V] = 1'b0;
                            OP_CLD: n_p[FB_D] = 1'b0;
                            OP_SED: n_p[FB_D] = 1'b1;
                            OP_ASL_A, OP_ROL_A, OP_LSR_A, OP_ROR_A: begin
                                fr  = f_shift(i_rdata[6:5], r_a, r_p);
                                n_a = fr[7:0]; n_p = fr[15:8];
                            end
                            default: n_pc = r_pc + 16'd1;
                        endcase
                    end
                    CL_PHP, CL_PHA: begin
                        mreq = '{en: 1'b1, we: 1'b1, addr: {STACK_PAGE, r_sp},
                                 wdata: (cls_in == CL_PHP) ? (r_p | PUSH_P_SET) : r_a};
                        n_sp = r_sp - 8'd1; n_pc = r_pc + 16'd1;
                    end
                    CL_PLP, CL_PLA, CL_RTI, CL_RTS: begin
                        n_sp = r_sp + 8'd1;
                        mreq = '{en: 1'b1, we: 1'b0, addr: {STACK_PAGE, n_sp}, wdata: 8'd0};
                    end
                    CL_BRK: n_step = 2'd0;
                    default: mreq = '{en: 1'b1, we: 1'b0, addr: r_pc + 16'd1, wdata: 8'd0};
                endcase
            end
            ST_B1: begin
                n_b1 = i_rdata;
                if (r_cls == CL_BRANCH) begin
                    unique case (r_op[7:6])
                        2'd0:    take = (r_p[FB_N] == r_op[5]);
                        2'd1:    take = (r_p[FB_V] == r_op[5]);
                        2'd2:    take = (r_p[FB_C] == r_op[5]);
                        default: take = (r_p[FB_Z] == r_op[5]);
                    endcase
                    if (take) begin
                        n_pc  = tgt;
                        n_cyc = r_cyc + ((tgt[15:8] != nxt[15:8]) ? 3'd2 : 3'd1);
                    end else begin
                        n_pc = nxt;
                    end
                end else if (r_cls == CL_MEM) begin
                    unique case (r_mode)
                        M_IMM: n_ea = r_pc + 16'd1;
                        M_ZP:  n_ea = {ZERO_PAGE, i_rdata};
                        M_ZPX: n_ea = {ZERO_PAGE, i_rdata + r_x};
                        M_ZPY: n_ea = {ZERO_PAGE, i_rdata + r_y};
                        M_IZX, M_IZY: begin
                            t8    = (r_mode == M_IZX) ? (i_rdata + r_x) : i_rdata;
                            mreq  = '{en: 1'b1, we: 1'b0, addr: {ZERO_PAGE, t8}, wdata: 8'd0};
                            n_ea2 = {ZERO_PAGE, t8 + 8'd1};
                        end
                        default: mreq = '{en: 1'b1, we: 1'b0, addr: r_pc + 16'd2, wdata: 8'd0};
                    endcase
                end else begin
                    mreq = '{en: 1'b1, we: 1'b0, addr: r_pc + 16'd2, wdata: 8'd0};
                end
            end
            ST_B2: begin
                unique case (r_cls)
                    CL_JMP: n_pc = w;
                    CL_JSR: begin n_ea = w; n_step = 2'd0; end
                    CL_JMPI: begin
                        mreq  = '{en: 1'b1, we: 1'b0, addr: w, wdata: 8'd0};
                        n_ea2 = {w[15:8], w[7:0] + 8'd1};
                    end
                    default: begin
                        if (r_mode == M_ABS) begin
                            n_ea = w;
                        end else begin
                            s16     = w + {8'd0, (r_mode == M_ABX) ? r_x : r_y};
                            n_ea    = s16;
                            n_cross = (s16[15:8] != w[15:8]);
                        end
                    end
                endcase
            end
            ST_VLO: begin
                n_lo = i_rdata;
                mreq = '{en: 1'b1, we: 1'b0, addr: r_ea2, wdata: 8'd0};
            end
            ST_VHI: begin
                w = {i_rdata, r_lo};
                if (r_cls != CL_MEM) begin
                    n_pc = w;
                end else if (r_mode == M_IZX) begin
                    n_ea = w;
                end else begin
                    s16     = w + {8'd0, r_y};
                    n_ea    = s16;
                    n_cross = (s16[15:8] != w[15:8]);
                end
            end
            ST_ADDR: begin
                n_pc = r_pc + ((r_mode == M_ABS || r_mode == M_ABX || r_mode == M_ABY)
                               ? 16'd3 : 16'd2);
                if (r_cross && ((grp == GRP_1 && aaa != AAA_STO) || aaa == AAA_LOD))
                    n_cyc = r_cyc + 3'd1;
                if (aaa == AAA_STO) begin
                    case (grp)
                        GRP_1:   t8 = r_a;
                        GRP_2:   t8 = r_x;
                        default: t8 = r_y;
                    endcase
                    mreq = '{en: 1'b1, we: 1'b1, addr: r_ea, wdata: t8};
                end else begin
                    mreq = '{en: 1'b1, we: 1'b0, addr: r_ea, wdata: 8'd0};
                end
            end
            ST_DATA: begin
                if (grp == GRP_1) begin
                    case (aaa)
                        AAA_ORA: begin n_a = r_a | m; n_p = f_nz(r_p, n_a); end
                        AAA_AND: begin n_a = r_a & m; n_p = f_nz(r_p, n_a); end
                        AAA_EOR: begin n_a = r_a ^ m; n_p = f_nz(r_p, n_a); end
                        AAA_ADC: begin fr = f_adc(r_a, m, r_p); n_a = fr[7:0]; n_p = fr[15:8]; end
                        AAA_LOD: begin n_a = m; n_p = f_nz(r_p, m); end
                        AAA_CMP: n_p = f_cmp(r_a, m, r_p);
                        default: begin fr = f_adc(r_a, ~m, r_p); n_a = fr[7:0]; n_p = fr[15:8]; end
                    endcase
                end else if (grp == GRP_2) begin
                    if (aaa == AAA_LOD) begin
                        n_x = m; n_p = f_nz(r_p, m);
                    end else begin
                        if (aaa == AAA_CMP) begin
                            t8 = m - 8'd1; n_p = f_nz(r_p, t8);
                        end else if (aaa == AAA_SBC) begin
                            t8 = m + 8'd1; n_p = f_nz(r_p, t8);
                        end else begin
                            fr = f_shift(aaa[1:0], m, r_p); t8 = fr[7:0]; n_p = fr[15:8];
                        end
                        mreq = '{en: 1'b1, we: 1'b1, addr: r_ea, wdata: t8};
                    end
                end else begin
                    case (aaa)
                        AAA_AND: begin
                            n_p[FB_Z] = ((r_a & m) == 8'd0);
                            n_p[FB_V] = m[6];
                            n_p[FB_N] = m[7];
                        end
                        AAA_LOD: begin n_y = m; n_p = f_nz(r_p, m); end
                        AAA_CMP: n_p = f_cmp(r_y, m, r_p);
                        default: n_p = f_cmp(r_x, m, r_p);
                    endcase
                end
            end
            ST_PUSH: begin
                n_step = r_step + 2'd1;
                if (r_cls == CL_BRK && r_step == 2'd3) begin
                    mreq  = '{en: 1'b1, we: 1'b0, addr: BRK_VEC_LO, wdata: 8'd0};
                    n_ea2 = BRK_VEC_HI;
                end else begin
                    case (r_step)
                        2'd0:    t8 = ret[15:8];
                        2'd1:    t8 = ret[7:0];
                        default: t8 = r_p | PUSH_P_SET;
                    endcase
                    mreq = '{en: 1'b1, we: 1'b1, addr: {STACK_PAGE, r_sp}, wdata: t8};
                    n_sp = r_sp - 8'd1;
                    if (r_step == 2'd2) n_p[FB_I] = 1'b1;
                    if (r_cls == CL_JSR && r_step == 2'd1) n_pc = r_ea;
                end
            end
            ST_PULL: begin
                n_step = r_step + 2'd1;
                case (r_cls)
                    CL_PLA: begin n_a = m; n_p = f_nz(r_p, m); n_pc = r_pc + 16'd1; end
                    CL_PLP: begin n_p = (m & PULL_P_MASK) | PULL_P_SET; n_pc = r_pc + 16'd1; end
                    CL_RTI: begin
                        if (r_step == 2'd0)      n_p = (m & PULL_P_MASK) | PULL_P_SET;
                        else if (r_step == 2'd1) n_lo = m;
                        else                     n_pc = {m, r_lo};
                    end
                    default: begin
                        if (r_step == 2'd0) n_lo = m;
                        else                n_pc = {m, r_lo} + 16'd1;
                    end
                endcase
                if (pull_more) begin
                    n_sp = r_sp + 8'd1;
                    mreq = '{en: 1'b1, we: 1'b0, addr: {STACK_PAGE, n_sp}, wdata: 8'd0};
                end
            end
            ST_FIN: mreq = '0;
            default: mreq = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= START_ADDR_RST;
            r_a     <= 8'd0;
            r_x     <= 8'd0;
            r_y     <= 8'd0;
            r_sp    <= SP_RST;
            r_p     <= P_RST;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_a     <= n_a;
            r_x     <= n_x;
            r_y     <= n_y;
            r_sp    <= n_sp;
            r_p     <= n_p;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls   <= n_cls;
        r_mode  <= n_mode;
        r_op    <= n_op;
        r_b1    <= n_b1;
        r_lo    <= n_lo;
        r_rdata <= n_rdata;
        r_ea    <= n_ea;
        r_ea2   <= n_ea2;
        r_cyc   <= n_cyc;
        r_unk   <= n_unk;
        r_cross <= n_cross;
        r_step  <= n_step;
    end

    assign o_res = '{read_data: r_rdata, pc_out: r_pc, acc_out: r_a, xreg_out: r_x,
                     yreg_out: r_y, sp_out: r_sp, status_out: r_p, cycles_taken: r_cyc,
                     opcode_out: r_op, unknown_op: r_unk};

endmodule

// ===== sv/cpu_6502_instruction_step.sv =====
// ----------------------------------------------------------------------------
// cpu_6502_instruction_step
// 6502 core without decimal mode over a flat byte memory; each word loads a
// byte, reads a byte or executes one instruction and returns the registers.
// ----------------------------------------------------------------------------
//  channel   direction  tdata (low bit up)                            tuser
//  s_axis    in         address[15:0] data[23:16]                     command[1:0]
//  m_axis    out        read_data pc acc x y sp status cycles opcode  unknown_op
//  cfg       in         start_address[15:0]                           -
//
//  A load goes from accept straight to the result, a read passes a wait
//  state, and an execute steps through decode and its single-port memory accesses.
//  Reset is synchronous and active low.
//  A result waits in the output register; the next word is taken meanwhile,
//  and its result holds in the core until the output register frees.
// ----------------------------------------------------------------------------
module cpu_6502_instruction_step #(
    parameter int unsigned MEM_ADDR_BITS = c65_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [c65_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // address, data
    input  logic [1:0]                          s_axis_tuser,   // command
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // read_data, pc_out, acc_out, xreg_out, yreg_out, sp_out, status_out,
    // cycles_taken, opcode_out, zero fill
    output logic [c65_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tuser,   // unknown_op
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [15:0]                         i_cfg_data
);
    import c65_pkg::*;

    t_mem_req   mem_req;
    logic [7:0] mem_rdata;
    logic       fin, ack;
    t_result    res;
    t_result    r_res;
    logic       r_ovalid;

    c65_mem #(.ADDR_BITS(MEM_ADDR_BITS)) u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    c65_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_addr      (s_axis_tdata[15:0]),
        .i_data      (s_axis_tdata[23:16]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_mem_req   (mem_req),
        .i_rdata     (mem_rdata),
        .o_fin       (fin),
        .i_ack       (ack),
        .o_res       (res)
    );

    assign ack         = !r_ovalid || m_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (fin && ack) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin && ack) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_res.unknown_op;
    assign m_axis_tdata  = {5'd0, r_res.opcode_out, r_res.cycles_taken, r_res.status_out,
                            r_res.sp_out, r_res.yreg_out, r_res.xreg_out, r_res.acc_out,
                            r_res.pc_out, r_res.read_data};

endmodule

// ===== sv/c65_chk.sv =====
// ----------------------------------------------------------------------------
// c65_chk
// Port checker for the 6502 step core, bound to the top level.
// ----------------------------------------------------------------------------
`include "cpu_6502_instruction_step_macros.svh"

module c65_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [c65_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [1:0]                      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [c65_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [15:0]                     i_cfg_data
);
    import c65_pkg::*;

    `C65_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")
    `C65_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "word taken while busy")
    `C65_ASSERT_IMP(a_unk_cycles, m_axis_tvalid && m_axis_tuser, m_axis_tdata[66:64] == 3'd2, "unknown opcode cycle count")
    `C65_ASSERT_IMP(a_noexec_clean, m_axis_tvalid && m_axis_tdata[66:64] == 3'd0, m_axis_tdata[74:67] == 8'd0 && !m_axis_tuser, "non-execute word carries opcode")
    `C65_ASSERT_IMP(a_status_bits, m_axis_tvalid, m_axis_tdata[61] && !m_axis_tdata[60], "status bit 5 or 4 wrong")

endmodule

bind cpu_6502_instruction_step c65_chk u_c65_chk (.*);

// ===== dv/cpu_6502_instruction_step_test.sv =====
// ----------------------------------------------------------------------------
// cpu_6502_instruction_step_test
// Fills the whole memory, then runs directed instructions, random programs,
// stalls and start-address changes; a built-in 6502 model predicts each
// result word and the bench compares it field by field.
// ----------------------------------------------------------------------------
module cpu_6502_instruction_step_test;
    timeunit 1ns;
    timeprecision 1ps;
    import c65_pkg::*;

    localparam int LIMIT   = 4_000_000;
    localparam int SETTLE  = 24;
    // base cycles by opcode, '0' = unofficial
    localparam string CYC_MAP = {
        "76000350322004602500046024000470", "66003350422044602500046024000470",
        "66000350322034602500046024000470", "66000350422054602500046024000470",
        "06003330202044402600444025200500", "26203330222044402500444024204440",
        "26003350222044602500046024000470", "26003350222044602500046024000470"};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    cpu_6502_instruction_step DUT (.*);

    always #1 i_clk = ~i_clk;

    // model state
    bit [7:0]  mem [0:65535];
    bit [15:0] cpu_start = START_ADDR_RST, cpu_pc = START_ADDR_RST;
    bit [7:0]  cpu_a, cpu_x, cpu_y, cpu_sp = SP_RST, cpu_p = P_RST;

    t_result pending_results [$];
    int  errors = 0;
    int  cycle_cnt = 0;
    int  hold_cycles = 0;
    bit  steady = 1'b0;

    function automatic bit [7:0] set_nz(bit [7:0] v);
        cpu_p[FB_Z] = (v == 8'd0);
        cpu_p[FB_N] = v[7];
        return v;
    endfunction

    function automatic void stack_push(bit [7:0] v);
        mem[{STACK_PAGE, cpu_sp}] = v;
        cpu_sp--;
    endfunction

    function automatic bit [7:0] stack_pull();
        cpu_sp++;
        return mem[{STACK_PAGE, cpu_sp}];
    endfunction

    function automatic void add_carry(bit [7:0] m);
        bit [8:0] s;
        s = {1'b0, cpu_a} + {1'b0, m} + {8'd0, cpu_p[FB_C]};
        cpu_p[FB_C] = s[8];
        cpu_p[FB_V] = ~(cpu_a[7] ^ m[7]) & (cpu_a[7] ^ s[7]);
        cpu_a = set_nz(s[7:0]);
    endfunction

    function automatic void compare_reg(bit [7:0] r, bit [7:0] m);
        cpu_p[FB_C] = (r >= m);
        void'(set_nz(r - m));
    endfunction

    function automatic bit [7:0] shift_rot(bit [2:0] kind, bit [7:0] v);
        bit [7:0] r;
        bit cin;
        cin = cpu_p[FB_C];
        case (kind[1:0])
            2'd0: begin r = {v[6:0], 1'b0}; cpu_p[FB_C] = v[7]; end
            2'd1: begin r = {v[6:0], cin};  cpu_p[FB_C] = v[7]; end
            2'd2: begin r = {1'b0, v[7:1]}; cpu_p[FB_C] = v[0]; end
            default: begin r = {cin, v[7:1]}; cpu_p[FB_C] = v[0]; end
        endcase
        return set_nz(r);
    endfunction

    function automatic t_mode addr_mode(bit [7:0] op);
        t_mode md;
        if (op[1:0] == GRP_1) begin
            case (op[4:2])
                3'd0: md = M_IZX;
                3'd1: md = M_ZP;
                3'd2: md = M_IMM;
                3'd3: md = M_ABS;
                3'd4: md = M_IZY;
                3'd5: md = M_ZPX;
                3'd6: md = M_ABY;
                default: md = M_ABX;
            endcase
        end else begin
            case (op[4:2])
                3'd0: md = M_IMM;
                3'd1: md = M_ZP;
                3'd2: md = M_ACC;
                3'd3: md = M_ABS;
                3'd5: md = (op[1:0] == GRP_2 && (op[7:5] == AAA_STO || op[7:5] == AAA_LOD))
                           ? M_ZPY : M_ZPX;
                3'd7: md = (op[1:0] == GRP_2 && (op[7:5] == AAA_STO || op[7:5] == AAA_LOD))
                           ? M_ABY : M_ABX;
                default: md = M_NONE;
            endcase
        end
        return md;
    endfunction

    function automatic bit [15:0] operand_addr(t_mode md, bit [15:0] pc, output bit pg);
        bit [7:0]  b1, b2, zp;
        bit [15:0] base, a;
        b1 = mem[pc + 16'd1];
        b2 = mem[pc + 16'd2];
        pg = 1'b0;
        case (md)
            M_IMM: a = pc + 16'd1;
            M_ZP:  a = {8'd0, b1};
            M_ZPX: a = {8'd0, b1 + cpu_x};
            M_ZPY: a = {8'd0, b1 + cpu_y};
            M_ABS: a = {b2, b1};
            M_IZX: begin
                zp = b1 + cpu_x;
                a = {mem[{8'd0, zp + 8'd1}], mem[{8'd0, zp}]};
            end
            M_IZY: begin
                base = {mem[{8'd0, b1 + 8'd1}], mem[{8'd0, b1}]};
                a = base + cpu_y;
                pg = (a[15:8] != base[15:8]);
            end
            default: begin
                base = {b2, b1};
                a = base + ((md == M_ABX) ? cpu_x : cpu_y);
                pg = (a[15:8] != base[15:8]);
            end
        endcase
        return a;
    endfunction

    function automatic void run_instruction(bit [7:0] op, output bit [3:0] cyc, output bit unk);
        bit [15:0] pc, t, nxt;
        bit [7:0]  m, lo, hi;
        bit [2:0]  aaa;
        bit [1:0]  cc;
        bit        pg, flag, rdop;
        t_mode     md;
        pc  = cpu_pc;
        cyc = CYC_MAP[op] - "0";
        aaa = op[7:5];
        cc  = op[1:0];
        unk = 1'b0;
        if (cyc == 0) begin
            unk = 1'b1;
            cpu_pc = pc + 16'd1;
            cyc = 2;
            return;
        end
        if (op[4:0] == 5'h10) begin
            nxt = pc + 16'd2;
            m = mem[pc + 16'd1];
            t = nxt + {{8{m[7]}}, m};
            case (op[7:6])
                2'd0: flag = cpu_p[FB_N];
                2'd1: flag = cpu_p[FB_V];
                2'd2: flag = cpu_p[FB_C];
                default: flag = cpu_p[FB_Z];
            endcase
            if (flag == op[5]) begin
                cyc += (t[15:8] != nxt[15:8]) ? 2 : 1;
                cpu_pc = t;
            end else begin
                cpu_pc = nxt;
            end
            return;
        end
        cpu_pc = pc + 16'd1;
        case (op)
            OP_BRK: begin
                t = pc + 16'd2;
                stack_push(t[15:8]);
                stack_push(t[7:0]);
                stack_push(cpu_p | PUSH_P_SET);
                cpu_p[FB_I] = 1'b1;
                cpu_pc = {mem[BRK_VEC_HI], mem[BRK_VEC_LO]};
                return;
            end
            OP_JSR: begin
                t = pc + 16'd2;
                stack_push(t[15:8]);
                stack_push(t[7:0]);
                cpu_pc = {mem[pc + 16'd2], mem[pc + 16'd1]};
                return;
            end
            OP_RTI: begin
                cpu_p = (stack_pull() & PULL_P_MASK) | PULL_P_SET;
                lo = stack_pull();
                hi = stack_pull();
                cpu_pc = {hi, lo};
                return;
            end
            OP_RTS: begin
                lo = stack_pull();
                hi = stack_pull();
                cpu_pc = {hi, lo} + 16'd1;
                return;
            end
            OP_JMP: begin cpu_pc = {mem[pc + 16'd2], mem[pc + 16'd1]}; return; end
            OP_JMPI: begin
                t = {mem[pc + 16'd2], mem[pc + 16'd1]};
                cpu_pc = {mem[{t[15:8], t[7:0] + 8'd1}], mem[t]};
                return;
            end
            OP_PHP: begin stack_push(cpu_p | PUSH_P_SET); return; end
            OP_PLP: begin cpu_p = (stack_pull() & PULL_P_MASK) | PULL_P_SET; return; end
            OP_PHA: begin stack_push(cpu_a); return; end
            OP_PLA: begin cpu_a = set_nz(stack_pull()); return; end
            OP_DEY: begin cpu_y = set_nz(cpu_y - 8'd1); return; end
            OP_INY: begin cpu_y = set_nz(cpu_y + 8'd1); return; end
            OP_DEX: begin cpu_x = set_nz(cpu_x - 8'd1); return; end
            OP_INX: begin cpu_x = set_nz(cpu_x + 8'd1); return; end
            OP_TXA: begin cpu_a = set_nz(cpu_x); return; end
            OP_TAX: begin cpu_x = set_nz(cpu_a); return; end
            OP_TYA: begin cpu_a = set_nz(cpu_y); return; end
            OP_TAY: begin cpu_y = set_nz(cpu_a); return; end
            OP_TXS: begin cpu_sp = cpu_x; return; end
            OP_TSX: begin cpu_x = set_nz(cpu_sp); return; end
            OP_NOP: return;
            OP_CLC: begin cpu_p[FB_C] = 1'b0; return; end
            OP_SEC: begin cpu_p[FB_C] = 1'b1; return; end
            OP_CLI: begin cpu_p[FB_I] = 1'b0; return; end
            OP_SEI: begin cpu_p[FB_I] = 1'b1; return; end
            OP_CLV: begin cpu_p[FB_V] = 1'b0; return; end
            OP_CLD: begin cpu_p[FB_D] = 1'b0; return; end
            OP_SED: begin cpu_p[FB_D] = 1'b1; return; end
            default: ;
        endcase
        md = addr_mode(op);
        if (md == M_NONE) begin
            unk = 1'b1;
            cyc = 2;
            return;
        end
        pg = 1'b0;
        t = (md == M_ACC) ? 16'd0 : operand_addr(md, pc, pg);
        cpu_pc = pc + ((md == M_ACC) ? 16'd1 :
                       (md == M_ABS || md == M_ABX || md == M_ABY) ? 16'd3 : 16'd2);
        rdop = (cc == GRP_1 && aaa != AAA_STO) || aaa == AAA_LOD;
        if (pg && rdop) cyc += 1;
        if (cc == GRP_1) begin
            if (aaa == AAA_STO) begin
                mem[t] = cpu_a;
                return;
            end
            m = mem[t];
            case (aaa)
                AAA_ORA: cpu_a = set_nz(cpu_a | m);
                AAA_AND: cpu_a = set_nz(cpu_a & m);
                AAA_EOR: cpu_a = set_nz(cpu_a ^ m);
                AAA_ADC: add_carry(m);
                AAA_LOD: cpu_a = set_nz(m);
                AAA_CMP: compare_reg(cpu_a, m);
                default: add_carry(~m);
            endcase
        end else if (cc == GRP_2) begin
            if (aaa < AAA_STO) begin
                if (md == M_ACC) cpu_a = shift_rot(aaa, cpu_a);
                else mem[t] = shift_rot(aaa, mem[t]);
            end else if (aaa == AAA_STO) mem[t] = cpu_x;
            else if (aaa == AAA_LOD) cpu_x = set_nz(mem[t]);
            else if (aaa == AAA_CMP) mem[t] = set_nz(mem[t] - 8'd1);
            else mem[t] = set_nz(mem[t] + 8'd1);
        end else begin
            m = (aaa == AAA_STO) ? 8'd0 : mem[t];
            case (aaa)
                AAA_AND: begin
                    cpu_p[FB_Z] = ((cpu_a & m) == 8'd0);
                    cpu_p[FB_V] = m[6];
                    cpu_p[FB_N] = m[7];
                end
                AAA_STO: mem[t] = cpu_y;
                AAA_LOD: cpu_y = set_nz(m);
                AAA_CMP: compare_reg(cpu_y, m);
                default: compare_reg(cpu_x, m);
            endcase
        end
    endfunction

    function automatic t_result step_cpu(bit [1:0] cmd, bit [15:0] addr, bit [7:0] val);
        t_result r;
        bit [3:0] cyc;
        bit unk;
        r = '0;
        if (cmd == CMD_LOAD) mem[addr] = val;
        else if (cmd == CMD_READ) r.read_data = mem[addr];
        else if (cmd == CMD_EXEC) begin
            r.opcode_out = mem[cpu_pc];
            run_instruction(r.opcode_out, cyc, unk);
            r.cycles_taken = cyc[2:0];
            r.unknown_op = unk;
        end
        r.pc_out = cpu_pc;
        r.acc_out = cpu_a;
        r.xreg_out = cpu_x;
        r.yreg_out = cpu_y;
        r.sp_out = cpu_sp;
        r.status_out = cpu_p;
        return r;
    endfunction

    task automatic send_word(bit [1:0] cmd, bit [15:0] addr, bit [7:0] val);
        if (!steady && $urandom_range(99) < 9) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, addr};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(step_cpu(cmd, addr, val));
    endtask

    task automatic drain();
        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_start(bit [15:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cpu_start = val;
        cpu_pc = val;
    endtask

    // places an instruction at the current pc and runs it
    task automatic exec_at(bit [7:0] op, bit [7:0] b1, bit [7:0] b2);
        bit [15:0] pc;
        pc = cpu_pc;
        send_word(CMD_LOAD, pc, op);
        send_word(CMD_LOAD, pc + 16'd1, b1);
        send_word(CMD_LOAD, pc + 16'd2, b2);
        send_word(CMD_EXEC, 16'($urandom), 8'($urandom));
    endtask

    task automatic test_fill_memory();
        for (int i = 0; i < 65536; i++) send_word(CMD_LOAD, 16'(i), 8'($urandom));
    endtask

    task automatic test_directed();
        send_word(CMD_LOAD, 16'h0000, 8'h00);
        send_word(CMD_LOAD, 16'hFFFF, 8'hFF);
        send_word(CMD_READ, 16'h0000, 8'hFF);
        send_word(CMD_READ, 16'hFFFF, 8'h00);
        exec_at(8'hA9, 8'h80, 8'h00);          // LDA #$80
        exec_at(8'h69, 8'h80, 8'h00);          // ADC overflow and carry
        exec_at(8'hE9, 8'h01, 8'h00);          // SBC borrow
        exec_at(8'h4A, 8'h00, 8'h00);          // LSR A
        exec_at(8'h02, 8'h00, 8'h00);          // unofficial
        exec_at(OP_JMPI, 8'hFF, 8'h10);        // indirect jump page wrap
        exec_at(8'hB1, 8'hFF, 8'h00);          // (zp),Y pointer wrap
        exec_at(OP_BRK, 8'h00, 8'h00);
        exec_at(OP_RTI, 8'h00, 8'h00);
    endtask

    task automatic test_random(int n, bit calm);
        int r;
        for (int i = 0; i < n; i++) begin
            steady = calm && (i > n / 3) && (i < 2 * n / 3);
            r = $urandom_range(99);
            if (r < 35) send_word(CMD_EXEC, 16'($urandom), 8'($urandom));
            else if (r < 55) begin
                exec_at(8'($urandom), 8'($urandom), 8'($urandom));
                i += 3;
            end else if (r < 65) send_word(CMD_LOAD, {8'h01, 8'($urandom)}, 8'($urandom));
            else if (r < 80) send_word(CMD_LOAD, 16'($urandom), 8'($urandom));
            else send_word(CMD_READ, 16'($urandom), 8'($urandom));
        end
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        steady = 1'b1;
        for (int i = 0; i < 40; i++) send_word(CMD_EXEC, 16'($urandom), 8'($urandom));
        steady = 1'b0;
    endtask

    task automatic test_start_address();
        write_start(16'h0000);
        test_random(200, 1'b0);
        write_start(16'hFFFF);
        test_random(200, 1'b0);
        write_start(16'($urandom));
        test_random(200, 1'b0);
        write_start(START_ADDR_RST);
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(99) >= 9);
        end
    end

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s expected %0h actual %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing pending");
                errors++;
            end else begin
                e = pending_results.pop_front();
                check_field("read_data", e.read_data, m_axis_tdata[7:0]);
                check_field("pc_out", e.pc_out, m_axis_tdata[23:8]);
                check_field("acc_out", e.acc_out, m_axis_tdata[31:24]);
                check_field("xreg_out", e.xreg_out, m_axis_tdata[39:32]);
                check_field("yreg_out", e.yreg_out, m_axis_tdata[47:40]);
                check_field("sp_out", e.sp_out, m_axis_tdata[55:48]);
                check_field("status_out", e.status_out, m_axis_tdata[63:56]);
                check_field("cycles_taken", e.cycles_taken, m_axis_tdata[66:64]);
                check_field("opcode_out", e.opcode_out, m_axis_tdata[74:67]);
                check_field("unknown_op", e.unknown_op, m_axis_tuser);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_memory();
        test_directed();
        test_backpressure();
        drain();
        test_random(700, 1'b1);
        test_start_address();
        test_random(100, 1'b0);
        drain();
        if (pending_results.size() == 0 && errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/c65_pkg.sv
sv/c65_mem.sv
sv/c65_core.sv
sv/cpu_6502_instruction_step.sv
sv/c65_chk.sv
dv/cpu_6502_instruction_step_test.sv
